// ===== rtl/bm_pkg.sv =====
`default_nettype none
package bm_pkg;

	localparam int DEF_MAX_PATTERN = 64;
	localparam int DEF_MAX_TEXT    = 4096;
	localparam int DEF_SYMBOLS     = 256;
	localparam int POS_W           = 12;
	localparam int COUNT_W         = 19;

	typedef struct packed {
		logic       kind;    // 0 = pattern byte, 1 = text byte
		logic [7:0] symbol;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic               found;
		logic [POS_W-1:0]   position;
		logic [COUNT_W-1:0] comparisons;
	} out_item_t;

	typedef enum logic [4:0] {
		OP_LOAD,
		OP_BS_CLR,
		OP_BS_RD,
		OP_BS_WR,
		OP_SUF_CLR,
		OP_GS_INIT,
		OP_GS_RD,
		OP_GS_CMP,
		OP_P2_RD0,
		OP_P2_LD,
		OP_P2_RD,
		OP_P2_WR,
		OP_SR_START,
		OP_SR_CHK,
		OP_SR_RD,
		OP_SR_CMP,
		OP_SR_SH1,
		OP_SR_SH2,
		OP_SR_SH3,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t  op;
		logic clr_idx;   // zero the index counter
	} cmd_t;

	typedef struct packed {
		logic pdone;
		logic bs_clr_last;
		logic fill_end_now;
		logic fill_end_next;
		logic i_eq_m;
		logic i_eq_1;
		logic gs_mism;
		logic end_ge_n;
		logic sr_eq;
		logic k_last;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

// ===== rtl/bm_dpath.sv =====
`default_nettype none
module bm_dpath #(
	parameter int MAX_PATTERN = bm_pkg::DEF_MAX_PATTERN,
	parameter int MAX_TEXT    = bm_pkg::DEF_MAX_TEXT,
	parameter int SYMBOLS     = bm_pkg::DEF_SYMBOLS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bm_pkg::cmd_t      cmd,
	input  logic              in_fire,
	input  bm_pkg::in_item_t  in_item,
	output bm_pkg::status_t   status,
	output logic              out_valid,
	input  logic              out_ready,
	output bm_pkg::out_item_t out_item
);
	import bm_pkg::*;

	localparam int PA = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int PW = $clog2(MAX_PATTERN + 2);
	localparam int CW = $clog2(MAX_PATTERN + 1);
	localparam int GD = MAX_PATTERN + 2;
	localparam int TA = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
	localparam int NW = $clog2(MAX_TEXT + 1);
	localparam int TW = $clog2(MAX_TEXT + MAX_PATTERN + 2);
	localparam int SW = $clog2(SYMBOLS);

	// memories
	logic [7:0]    pmem [MAX_PATTERN];
	logic [7:0]    tmem [MAX_TEXT];
	logic [PW-1:0] bad_mem [SYMBOLS];
	logic [PW-1:0] suf_mem [GD];
	logic [PW-1:0] brd_mem [GD];

	logic [CW-1:0]      pcount_q;
	logic [NW-1:0]      tcount_q;
	logic               pdone_q;
	logic [PW-1:0]      i_q, j_q;
	logic [SW-1:0]      sw_q;
	logic [TW-1:0]      end_q;
	logic [COUNT_W-1:0] count_q;
	logic               found_q;
	logic [POS_W-1:0]   pos_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic [7:0]    pa_rd, pb_rd, t_rd;
	logic [PW-1:0] bad_rd, suf_rd, brd_rd;

	logic [PW-1:0] m;
	logic [CW-1:0] pc_eff;
	logic [PA-1:0] pa_addr, pb_addr, pw_addr;
	logic [TA-1:0] t_addr, tw_addr;
	logic [SW-1:0] bad_addr, bw_addr;
	logic [PW-1:0] suf_addr, brd_addr, sw_addr, bw2_addr, suf_wd, brd_wd, bad_wd, shift;
	logic          pw_en, tw_en, bad_en, suf_en, brd_en;
	logic          out_free;

	function automatic logic [SW-1:0] slot(input logic [7:0] s);
		return (int'(s) >= SYMBOLS) ? SW'(SYMBOLS - 1) : s[SW-1:0];
	endfunction

	assign m        = PW'(pcount_q);
	assign pc_eff   = pdone_q ? '0 : pcount_q;
	assign out_free = !out_valid_q || out_ready;

	// read addresses
	always_comb begin
		pa_addr  = i_q[PA-1:0];
		pb_addr  = PA'(j_q - 1'b1);
		t_addr   = end_q[TA-1:0];
		suf_addr = j_q;
		brd_addr = j_q;
		unique case (cmd.op) inside
			OP_GS_RD:  pa_addr = PA'(i_q - 1'b1);
			OP_SR_RD: begin
				pa_addr = PA'(m - 1'b1 - i_q);
				t_addr  = TA'(end_q - TW'(i_q));
			end
			OP_P2_RD0: brd_addr = '0;
			OP_P2_RD:  suf_addr = i_q;
			OP_SR_SH1, OP_SR_SH2: suf_addr = m - i_q;
			default: ;
		endcase
		bad_addr = slot(t_rd);
	end

	// write ports
	always_comb begin
		pw_en    = 1'b0;
		pw_addr  = pc_eff[PA-1:0];
		tw_en    = 1'b0;
		tw_addr  = tcount_q[TA-1:0];
		bad_en   = 1'b0;
		bw_addr  = sw_q;
		bad_wd   = m;
		suf_en   = 1'b0;
		sw_addr  = i_q;
		suf_wd   = '0;
		brd_en   = 1'b0;
		bw2_addr = m;
		brd_wd   = m + 1'b1;
		unique case (cmd.op)
			OP_LOAD: begin
				if (in_fire && !in_item.kind)
					pw_en = pc_eff < CW'(MAX_PATTERN);
				if (in_fire && in_item.kind && pdone_q)
					tw_en = tcount_q < NW'(MAX_TEXT);
			end
			OP_BS_CLR: bad_en = 1'b1;
			OP_BS_WR: begin
				bad_en  = 1'b1;
				bw_addr = slot(pa_rd);
				bad_wd  = m - 1'b1 - i_q;
			end
			OP_SUF_CLR: suf_en = 1'b1;
			OP_GS_INIT: brd_en = 1'b1;
			OP_GS_CMP: begin
				if (status.gs_mism) begin
					suf_en  = (suf_rd == '0);
					sw_addr = j_q;
					suf_wd  = j_q - i_q;
				end else begin
					brd_en   = 1'b1;
					bw2_addr = i_q - 1'b1;
					brd_wd   = j_q - 1'b1;
				end
			end
			OP_P2_WR: begin
				suf_en = (suf_rd == '0);
				suf_wd = j_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pw_en)
			pmem[pw_addr] <= in_item.symbol;
		pa_rd <= pmem[pa_addr];
		pb_rd <= pmem[pb_addr];
	end

	always_ff @(posedge clk) begin
		if (tw_en)
			tmem[tw_addr] <= in_item.symbol;
		t_rd <= tmem[t_addr];
	end

	always_ff @(posedge clk) begin
		if (bad_en)
			bad_mem[bw_addr] <= bad_wd;
		bad_rd <= bad_mem[bad_addr];
	end

	always_ff @(posedge clk) begin
		if (suf_en)
			suf_mem[sw_addr] <= suf_wd;
		suf_rd <= suf_mem[suf_addr];
	end

	always_ff @(posedge clk) begin
		if (brd_en)
			brd_mem[bw2_addr] <= brd_wd;
		brd_rd <= brd_mem[brd_addr];
	end

	assign shift = (bad_rd > suf_rd) ? bad_rd : suf_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_q    <= '0;
			tcount_q    <= '0;
			pdone_q     <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			sw_q        <= '0;
			end_q       <= '0;
			count_q     <= '0;
			found_q     <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_EMIT && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (cmd.op)
				OP_LOAD: begin
					sw_q <= '0;
					i_q  <= '0;
					if (in_fire && !in_item.kind) begin
						pdone_q <= in_item.last;
						if (pdone_q)
							tcount_q <= '0;
						pcount_q <= pw_en ? CW'(pc_eff + 1'b1) : pc_eff;
					end
					if (tw_en)
						tcount_q <= tcount_q + 1'b1;
				end
				OP_BS_CLR:  sw_q <= sw_q + 1'b1;
				OP_BS_WR:   i_q <= i_q + 1'b1;
				OP_SUF_CLR: i_q <= i_q + 1'b1;
				OP_GS_INIT: begin
					i_q <= m;
					j_q <= m + 1'b1;
				end
				OP_GS_CMP: begin
					if (status.gs_mism) begin
						j_q <= brd_rd;
					end else begin
						i_q <= i_q - 1'b1;
						j_q <= j_q - 1'b1;
					end
				end
				OP_P2_LD: begin
					j_q <= brd_rd;
					i_q <= '0;
				end
				OP_P2_WR: begin
					if (i_q == j_q)
						j_q <= brd_rd;
					i_q <= i_q + 1'b1;
				end
				OP_SR_START: begin
					end_q   <= TW'(m) - 1'b1;
					count_q <= '0;
					found_q <= 1'b0;
					pos_q   <= '0;
				end
				OP_SR_CHK: i_q <= '0;
				OP_SR_CMP: begin
					if (count_q != '1)
						count_q <= count_q + 1'b1;
					if (status.sr_eq) begin
						i_q <= i_q + 1'b1;
						if (status.k_last) begin
							found_q <= 1'b1;
							pos_q   <= POS_W'(end_q - TW'(m) + 1'b1);
						end
					end
				end
				OP_SR_SH3: end_q <= end_q + TW'(shift);
				OP_EMIT: begin
					if (out_free)
						tcount_q <= '0;
				end
				default: ;
			endcase
			if (cmd.clr_idx)
				i_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_EMIT && out_free)
			out_q <= '{found: found_q, position: pos_q, comparisons: count_q};
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		status.pdone         = pdone_q;
		status.bs_clr_last   = (sw_q == SW'(SYMBOLS - 1));
		status.fill_end_now  = ({1'b0, i_q} + 1'b1) >= {1'b0, m};
		status.fill_end_next = ({1'b0, i_q} + 2'd2) >= {1'b0, m};
		status.i_eq_m        = (i_q == m);
		status.i_eq_1        = (i_q == PW'(1));
		status.gs_mism       = (j_q <= m) && (pa_rd != pb_rd);
		status.end_ge_n      = end_q >= TW'(tcount_q);
		status.sr_eq         = (pa_rd == t_rd);
		status.k_last        = ({1'b0, i_q} + 1'b1) == {1'b0, m};
		status.out_free      = out_free;
	end

endmodule
`default_nettype wire

// ===== rtl/bm_ctrl.sv =====
`default_nettype none
module bm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_fire,
	input  bm_pkg::in_item_t in_item,
	input  bm_pkg::status_t  status,
	output bm_pkg::cmd_t     cmd,
	output logic             idle
);
	import bm_pkg::*;

	typedef enum logic [19:0] {
		S_IDLE     = 20'h00001,
		S_BS_CLR   = 20'h00002,
		S_BS_RD    = 20'h00004,
		S_BS_WR    = 20'h00008,
		S_SUF_CLR  = 20'h00010,
		S_GS_INIT  = 20'h00020,
		S_GS_RD    = 20'h00040,
		S_GS_CMP   = 20'h00080,
		S_P2_RD0   = 20'h00100,
		S_P2_LD    = 20'h00200,
		S_P2_RD    = 20'h00400,
		S_P2_WR    = 20'h00800,
		S_SR_START = 20'h01000,
		S_SR_CHK   = 20'h02000,
		S_SR_RD    = 20'h04000,
		S_SR_CMP   = 20'h08000,
		S_SR_SH1   = 20'h10000,
		S_SR_SH2   = 20'h20000,
		S_SR_SH3   = 20'h40000,
		S_DONE     = 20'h80000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d     = state_q;
		cmd.op      = OP_LOAD;
		cmd.clr_idx = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd.op = OP_LOAD;
				if (in_fire && in_item.last) begin
					if (!in_item.kind)
						state_d = S_BS_CLR;
					else if (status.pdone)
						state_d = S_SR_START;
				end
			end
			S_BS_CLR: begin
				cmd.op = OP_BS_CLR;
				if (status.bs_clr_last)
					state_d = status.fill_end_now ? S_SUF_CLR : S_BS_RD;
			end
			S_BS_RD: begin
				cmd.op  = OP_BS_RD;
				state_d = S_BS_WR;
			end
			S_BS_WR: begin
				cmd.op = OP_BS_WR;
				if (status.fill_end_next) begin
					cmd.clr_idx = 1'b1;
					state_d     = S_SUF_CLR;
				end else begin
					state_d = S_BS_RD;
				end
			end
			S_SUF_CLR: begin
				cmd.op = OP_SUF_CLR;
				if (status.i_eq_m)
					state_d = S_GS_INIT;
			end
			S_GS_INIT: begin
				cmd.op  = OP_GS_INIT;
				state_d = S_GS_RD;
			end
			S_GS_RD: begin
				cmd.op  = OP_GS_RD;
				state_d = S_GS_CMP;
			end
			S_GS_CMP: begin
				cmd.op  = OP_GS_CMP;
				state_d = (!status.gs_mism && status.i_eq_1) ? S_P2_RD0 : S_GS_RD;
			end
			S_P2_RD0: begin
				cmd.op  = OP_P2_RD0;
				state_d = S_P2_LD;
			end
			S_P2_LD: begin
				cmd.op  = OP_P2_LD;
				state_d = S_P2_RD;
			end
			S_P2_RD: begin
				cmd.op  = OP_P2_RD;
				state_d = S_P2_WR;
			end
			S_P2_WR: begin
				cmd.op  = OP_P2_WR;
				state_d = status.i_eq_m ? S_IDLE : S_P2_RD;
			end
			S_SR_START: begin
				cmd.op  = OP_SR_START;
				state_d = S_SR_CHK;
			end
			S_SR_CHK: begin
				cmd.op  = OP_SR_CHK;
				state_d = status.end_ge_n ? S_DONE : S_SR_RD;
			end
			S_SR_RD: begin
				cmd.op  = OP_SR_RD;
				state_d = S_SR_CMP;
			end
			S_SR_CMP: begin
				cmd.op = OP_SR_CMP;
				if (!status.sr_eq)
					state_d = S_SR_SH1;
				else if (status.k_last)
					state_d = S_DONE;
				else
					state_d = S_SR_RD;
			end
			S_SR_SH1: begin
				cmd.op  = OP_SR_SH1;
				state_d = S_SR_SH2;
			end
			S_SR_SH2: begin
				cmd.op  = OP_SR_SH2;
				state_d = S_SR_SH3;
			end
			S_SR_SH3: begin
				cmd.op  = OP_SR_SH3;
				state_d = S_SR_CHK;
			end
			S_DONE: begin
				cmd.op = OP_EMIT;
				if (status.out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign idle = (state_q == S_IDLE);

endmodule
`default_nettype wire

// ===== rtl/boyer_moore_first_match.sv =====
`default_nettype none
// Boyer-Moore first-match search.
// Input channel (in_valid/in_ready, in_item): pattern bytes (kind 0) then text
// bytes (kind 1), one item per cycle while idle. The item with last set closes
// the pattern or the text. Text items arriving with no complete pattern are
// dropped; bytes beyond MAX_PATTERN / MAX_TEXT are dropped but last still acts.
// Closing the pattern starts table building, with in_ready low until the
// tables are built and the controller is back in idle.
// Closing the text starts the search: a start state, then per window a check
// state, a read and a compare state per byte comparison and the shift states
// per shift, then a done state that hands over the result; reads are registered.
// Output channel (out_valid/out_ready, out_item): one item per text, carrying
// found, first match position and comparison count. The result sits in an
// output register; if it has not been taken when the next result is ready the
// controller waits in its done state. Input is taken again once back in idle.
// Reset clears the pattern and text counts; no pattern is held afterwards.
module boyer_moore_first_match #(
	parameter int MAX_PATTERN = bm_pkg::DEF_MAX_PATTERN,
	parameter int MAX_TEXT    = bm_pkg::DEF_MAX_TEXT,
	parameter int SYMBOLS     = bm_pkg::DEF_SYMBOLS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bm_pkg::in_item_t  in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output bm_pkg::out_item_t out_item
);
	import bm_pkg::*;

	cmd_t    cmd;
	status_t status;
	logic    idle;
	logic    in_fire;

	// items only land while the controller sits in idle
	assign in_ready = idle;
	assign in_fire  = in_valid && in_ready;

	bm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.in_item (in_item),
		.status  (status),
		.cmd     (cmd),
		.idle    (idle)
	);

	bm_dpath #(
		.MAX_PATTERN (MAX_PATTERN),
		.MAX_TEXT    (MAX_TEXT),
		.SYMBOLS     (SYMBOLS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_fire   (in_fire),
		.in_item   (in_item),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule
`default_nettype wire
